// ===== hw/rtl/spfu_pkg.sv =====
package spfu_pkg;

    localparam logic [2:0] FMT_444 = 3'd3;
    localparam logic [2:0] FMT_565 = 3'd5;
    localparam logic [2:0] FMT_666 = 3'd6;

    localparam logic [2:0] FMT_RESET = FMT_666;

    localparam logic       REG_COLOR_FORMAT = 1'b0;

    localparam int PIXEL_W = 24;

    typedef struct packed {
        logic [1:0]         pos;
        logic [PIXEL_W-1:0] partial;
        logic [PIXEL_W-1:0] carried;
    } t_state;

endpackage

// ===== hw/rtl/spfu_unpack.sv =====
module spfu_unpack import spfu_pkg::*; (
    input  logic [7:0]         i_data_byte,
    input  logic               i_burst_start,
    input  logic [2:0]         i_format,
    input  t_state             i_state,
    output t_state             o_state,
    output logic               o_emit,
    output logic [PIXEL_W-1:0] o_pixel
);

    logic [3:0] lo;
    logic [3:0] hi;
    logic [2:0] count;
    logic [1:0] base;
    logic [2:0] step;
    logic [1:0] pos;

    assign lo    = i_data_byte[3:0];
    assign hi    = i_data_byte[7:4];
    assign count = (i_format == FMT_565) ? 3'd2 : 3'd3;
    assign base  = i_burst_start ? 2'd0 : i_state.pos;
    assign step  = {1'b0, base} + 3'd1;
    assign pos   = (step > count) ? 2'd1 : step[1:0];

    always_comb begin
        o_state     = i_state;
        o_state.pos = pos;
        o_emit      = 1'b0;
        unique case (i_format)
            FMT_444: begin
                if (pos == 2'd1) begin
                    o_state.carried = {hi, 4'b0, lo, 12'b0};
                end else if (pos == 2'd2) begin
                    o_state.partial = i_state.carried | {16'b0, hi, 4'b0};
                    o_state.carried = {lo, 20'b0};
                    o_emit          = 1'b1;
                end else begin
                    o_state.partial = i_state.carried | {8'b0, hi, 4'b0, lo, 4'b0};
                    o_emit          = 1'b1;
                end
            end
            FMT_565: begin
                if (pos == 2'd1) begin
                    o_state.partial = {i_data_byte[7:3], 3'b0, i_data_byte[2:0], 13'b0};
                end else begin
                    o_state.partial = i_state.partial
                                    | {11'b0, i_data_byte[7:5], 2'b0, i_data_byte[4:0], 3'b0};
                    o_emit          = 1'b1;
                end
            end
            FMT_666: begin
                if (pos == 2'd1) begin
                    o_state.partial = {i_data_byte[7:2], 18'b0};
                end else if (pos == 2'd2) begin
                    o_state.partial = i_state.partial | {8'b0, i_data_byte[7:2], 10'b0};
                end else begin
                    o_state.partial = i_state.partial | {16'b0, i_data_byte[7:2], 2'b0};
                    o_emit          = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_pixel = o_state.partial;

endmodule

// ===== hw/rtl/spi_pixel_format_unpacker.sv =====
// Unpacks display RAM write bytes into 24-bit RGB pixels (red 23:16, green 15:8, blue 7:0),
// with components left-aligned in their bytes. One byte is taken in every cycle and a pixel
// appears on the output in the cycle after the byte that completes it; a single output register
// decouples the two sides, so a byte is still taken while a pixel waits, unless that pixel is
// stalled. Set burst start on the first byte after a RAM write command. The colour format
// register (address 0, reset 6) selects 4/4/4, 5/6/5 or 6/6/6; other codes swallow bytes.
module spi_pixel_format_unpacker import spfu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_burst_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [PIXEL_W-1:0] o_pixel_color
);

    logic [2:0]         r_format;
    t_state             r_state;
    t_state             n_state;
    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_pixel;
    logic [PIXEL_W-1:0] n_pixel;
    logic               emit;
    logic               in_acc;
    logic               out_acc;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready & (paddr[2] == REG_COLOR_FORMAT);
    assign prdata  = (paddr[2] == REG_COLOR_FORMAT) ? {29'b0, r_format} : 32'b0;

    assign o_stall = r_out_valid & i_stall;
    assign in_acc  = i_valid & ~o_stall;
    assign out_acc = r_out_valid & ~i_stall;

    spfu_unpack u_unpack (
        .i_data_byte   (i_data_byte),
        .i_burst_start (i_burst_start),
        .i_format      (r_format),
        .i_state       (r_state),
        .o_state       (n_state),
        .o_emit        (emit),
        .o_pixel       (n_pixel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format    <= FMT_RESET;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_format <= pwdata[2:0];
            end
            if (in_acc) begin
                r_state <= n_state;
            end
            if (in_acc && emit) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_color = r_pixel;

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state.pos != 2'd0)
        else $error("byte position left at zero after a request");

    a_pos_565: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_format == FMT_565 |=> r_state.pos != 2'd3)
        else $error("5/6/5 byte position beyond two");

    a_out_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(in_acc))
        else $error("pixel appeared without a request");

endmodule

// ===== sim/tb.sv =====
module tb;
    import spfu_pkg::*;

    class pixel_scoreboard;
        logic [2:0]         fmt;
        logic [1:0]         pos;
        logic [PIXEL_W-1:0] partial;
        logic [PIXEL_W-1:0] carried;
        logic [PIXEL_W-1:0] expected_pixels[$];
        int                 mismatches;
        int                 bytes_seen;
        int                 pixels_seen;

        function new();
            fmt         = FMT_RESET;
            pos         = 2'd0;
            partial     = '0;
            carried     = '0;
            mismatches  = 0;
            bytes_seen  = 0;
            pixels_seen = 0;
        endfunction

        function void set_format(input logic [2:0] code);
            fmt = code;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        function void note_byte(input logic [7:0] b, input logic burst);
            int   count;
            int   nxt;
            logic emit;
            count = (fmt == FMT_565) ? 2 : 3;
            emit  = 1'b0;
            bytes_seen++;
            if (burst) begin
                pos = 2'd0;
            end
            nxt = pos + 1;
            if (nxt > count) begin
                nxt = 1;
            end
            pos = nxt[1:0];
            case (fmt)
                FMT_444: begin
                    if (pos == 2'd1) begin
                        carried = {b[7:4], 4'h0, b[3:0], 12'h0};
                    end else if (pos == 2'd2) begin
                        partial = carried | {16'h0, b[7:4], 4'h0};
                        carried = {b[3:0], 20'h0};
                        emit    = 1'b1;
                    end else begin
                        partial = carried | {8'h0, b[7:4], 4'h0, b[3:0], 4'h0};
                        emit    = 1'b1;
                    end
                end
                FMT_565: begin
                    if (pos == 2'd1) begin
                        partial = {b[7:3], 3'b0, b[2:0], 13'h0};
                    end else begin
                        partial = partial | {11'h0, b[7:5], 2'b0, b[4:0], 3'b0};
                        emit    = 1'b1;
                    end
                end
                FMT_666: begin
                    if (pos == 2'd1) begin
                        partial = {b[7:2], 2'b0, 16'h0};
                    end else if (pos == 2'd2) begin
                        partial = partial | {8'h0, b[7:2], 2'b0, 8'h0};
                    end else begin
                        partial = partial | {16'h0, b[7:2], 2'b0};
                        emit    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (emit) begin
                expected_pixels.push_back(partial);
            end
        endfunction

        task check_pixel(input logic [PIXEL_W-1:0] got);
            logic [PIXEL_W-1:0] want;
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %06h arrived with none expected", got));
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("pixel %06h, expected %06h", got, want));
                end
            end
        endtask
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [2:0]         paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic [7:0]         i_data_byte   = '0;
    logic               i_burst_start = 1'b0;
    logic               o_valid;
    logic               i_stall       = 1'b0;
    logic [PIXEL_W-1:0] o_pixel_color;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int format_writes  = 0;

    pixel_scoreboard sb = new();

    spi_pixel_format_unpacker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_burst_start (i_burst_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_color (o_pixel_color)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_pixel(o_pixel_color);
            end
            if (i_valid && !o_stall) begin
                sb.note_byte(i_data_byte, i_burst_start);
            end
        end
        i_stall <= i_rst_n && ($urandom_range(99) < sink_stall_pct);
    end

    task automatic send_byte(input logic [7:0] d, input logic burst);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= d;
        i_burst_start <= burst;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_for_pixels(input int settle);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_color_format(input logic [2:0] code);
        logic [31:0] readback;
        wait_for_pixels(4);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_COLOR_FORMAT, 2'b00};
        pwdata  <= {29'h0, code};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_format(code);
        format_writes++;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (readback[2:0] !== code) begin
            sb.report_mismatch($sformatf("format register reads %0d, written %0d",
                                         readback[2:0], code));
        end
    endtask

    task automatic run_segment(input int n_items);
        int          left;
        int          len;
        int          unit;
        logic        burst;
        logic [7:0]  d;
        left = n_items;
        unit = (sb.fmt == FMT_565) ? 2 : 3;
        while (left > 0) begin
            len = unit * $urandom_range(1, 8);
            for (int k = 0; k < len && left > 0; k++) begin
                burst = (k == 0) ? ($urandom_range(99) < 85) : 1'b0;
                if ($urandom_range(99) < 4) begin
                    burst = ~burst;
                end
                d = 8'($urandom);
                if ($urandom_range(9) == 0) begin
                    d = $urandom_range(1) ? 8'hFF : 8'h00;
                end
                send_byte(d, burst);
                left--;
                if (left == n_items / 2) begin
                    wait_for_pixels(0);
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset format is 6/6/6; the first bursts run without a write.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h03, 1'b1);
        send_byte(8'hFC, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA4, 1'b1);
        send_byte(8'h5B, 1'b0);

        set_color_format(FMT_565);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);

        set_color_format(FMT_444);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);

        // Codes without a mode swallow bytes; the position keeps counting into 6/6/6.
        set_color_format(3'd0);
        send_byte(8'h81, 1'b1);
        set_color_format(3'd7);
        send_byte(8'h7E, 1'b0);
        set_color_format(FMT_666);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);

        for (int seg = 0; seg < 22; seg++) begin
            case (seg % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            if (seg < 8) begin
                set_color_format(seg[2:0]);
            end else begin
                case ($urandom_range(2))
                    0: set_color_format(FMT_444);
                    1: set_color_format(FMT_565);
                    default: set_color_format(FMT_666);
                endcase
            end
            if (sb.fmt == FMT_444 || sb.fmt == FMT_565 || sb.fmt == FMT_666) begin
                run_segment(60);
            end else begin
                run_segment(8);
            end
        end

        wait_for_pixels(4);
        $display("Sent %0d bytes and checked %0d pixels over %0d format register writes,",
                 sb.bytes_seen, sb.pixels_seen, format_writes);
        $display("covering every format code, burst restarts and four idle/stall mixes.");
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
